// ===== hw/rtl/drf_pkg.sv =====
// Shared constants, types and arithmetic helpers of the delta regression feature block.
package drf_pkg;

    localparam int COLUMNS    = 64;
    localparam int COL_W      = 6;
    localparam int VAL_W      = 24;
    localparam int SUM_W      = 27;
    localparam int HIST       = 4;
    localparam int CFG_AW     = 5;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int DIV_SHIFT  = 30;

    localparam logic [SUM_W-1:0] RECIP10    = 27'd107374183;
    localparam logic [SUM_W-1:0] ROUND_BIAS = 27'd5;
    localparam logic [6:0]       COLUMNS_RESET = 7'd13;
    localparam logic [2:0]       FRAMES_FOR_DELTA = 3'd4;
    localparam logic [2:0]       FRAMES_FOR_ACCEL = 3'd7;
    localparam logic [2:0]       FRAME_COUNT_MAX  = 3'd7;

    typedef enum logic [2:0] {
        REG_DELTA_EN        = 3'd0,
        REG_ENERGY_DELTA_EN = 3'd1,
        REG_ACCEL_EN        = 3'd2,
        REG_ENERGY_ACCEL_EN = 3'd3,
        REG_COLUMNS         = 3'd4
    } reg_index_t;

    typedef logic [VAL_W-1:0] sample_t;

    typedef struct packed {
        sample_t [HIST-1:0] base;
        sample_t [HIST-1:0] delta;
    } row_t;

    typedef struct packed {
        sample_t          delta_value;
        logic             delta_valid;
        sample_t          accel_value;
        logic             accel_valid;
        logic [COL_W-1:0] column;
        logic             frame_end;
    } result_t;

    function automatic logic signed [SUM_W-1:0] widen(input sample_t v);
        return $signed({{(SUM_W-VAL_W){v[VAL_W-1]}}, v});
    endfunction

    // Rounds to nearest with ties away from zero; exact for magnitudes below 2**27.
    function automatic sample_t div10_round(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0]   mag;
        logic [SUM_W-1:0]   n;
        logic [2*SUM_W-1:0] prod;
        sample_t            q;
        mag  = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        n    = mag + ROUND_BIAS;
        prod = n * RECIP10;
        q    = prod[DIV_SHIFT+VAL_W-1:DIV_SHIFT];
        return s[SUM_W-1] ? VAL_W'(-q) : q;
    endfunction

endpackage

// ===== hw/rtl/delta_regression_features.sv =====
// Top level of the delta and delta-delta regression feature block.
//
// Feature elements enter on the input channel (in_valid, in_stall) one per
// cycle while in_stall is low, each with its column index and frame markers.
// Every item gives one result item on the output channel (out_valid,
// out_stall) carrying the delta of frame n-2 and the delta-delta of frame n-4
// for that column. The per-column history of four base values and four deltas
// lives in one synchronous memory that is read at acceptance and written
// back from the second stage; same-column items in flight are forwarded, so
// one item per cycle is sustained for any column order while in_stall is low.
// Results pass through the three compute stages and an eight-entry output
// queue before out_valid shows them; the input is stalled only when the queue
// and the three compute stages together hold eight items, so while the
// receiver stalls, input is still accepted until the queue and the stages are
// full between them, and the queue never overflows.
// Reset clears the frame count, the queue and a valid bit per column, so
// every history row reads as zero until it is first written; no clearing
// pass is needed. Configuration registers return to their reset values.
module delta_regression_features
    import drf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_AW-1:0]       paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [VAL_W-1:0] feature_value,
    input  logic [COL_W-1:0]        column,
    input  logic                    is_energy,
    input  logic                    frame_end,
    input  logic                    utterance_start,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [VAL_W-1:0] delta_value,
    output logic                    delta_valid,
    output logic signed [VAL_W-1:0] accel_value,
    output logic                    accel_valid,
    output logic [COL_W-1:0]        column_out,
    output logic                    frame_end_out
);

    logic       delta_en_reg;
    logic       energy_delta_en_reg;
    logic       accel_en_reg;
    logic       energy_accel_en_reg;
    logic [6:0] columns_reg;
    logic [2:0] frame_count_reg;
    logic [2:0] frame_count_used;
    logic [2:0] frame_count_next;

    logic       cfg_write;
    logic [2:0] cfg_index;

    logic       accept;
    logic       in_use;

    row_t       hist_mem [COLUMNS];
    logic [COLUMNS-1:0] row_valid_reg;
    row_t       rd_row_reg;
    logic       rd_ok_reg;

    row_t             lw_row_reg;
    logic [COL_W-1:0] lw_col_reg;
    logic             lw_valid_reg;

    logic             s1_valid_reg;
    sample_t          s1_value_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_fend_reg;
    logic             s1_use_reg;
    logic             s1_den_reg;
    logic             s1_aen_reg;
    logic             s1_ge4_reg;
    logic             s1_ge7_reg;

    row_t                    s1_mem_row;
    sample_t [HIST-1:0]      s1_base;
    sample_t [HIST-1:0]      s1_delta;
    logic signed [SUM_W-1:0] s1_sum;

    logic                    s2_valid_reg;
    logic [COL_W-1:0]        s2_col_reg;
    logic                    s2_fend_reg;
    logic                    s2_use_reg;
    logic                    s2_den_reg;
    logic                    s2_aen_reg;
    logic                    s2_ge4_reg;
    logic                    s2_ge7_reg;
    logic signed [SUM_W-1:0] s2_sum_reg;
    sample_t [HIST-1:0]      s2_base_reg;
    sample_t [HIST-1:0]      s2_delta_reg;

    sample_t [HIST-1:0]      s2_dh;
    sample_t                 s2_d;
    row_t                    wr_row;
    logic                    wr_en;
    logic signed [SUM_W-1:0] s2_partial;

    logic                    s3_valid_reg;
    logic [COL_W-1:0]        s3_col_reg;
    logic                    s3_fend_reg;
    logic                    s3_dout_reg;
    logic                    s3_aout_reg;
    sample_t                 s3_d_reg;
    logic signed [SUM_W-1:0] s3_partial_reg;

    logic signed [SUM_W-1:0] s3_sum;
    result_t                 s3_result;

    result_t              fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     fifo_count_reg;
    logic [FIFO_AW+1:0]   pending;
    logic                 pop;
    result_t              head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_en_reg        <= 1'b0;
            energy_delta_en_reg <= 1'b0;
            accel_en_reg        <= 1'b0;
            energy_accel_en_reg <= 1'b0;
            columns_reg         <= COLUMNS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DELTA_EN:        delta_en_reg        <= pwdata[0];
                REG_ENERGY_DELTA_EN: energy_delta_en_reg <= pwdata[0];
                REG_ACCEL_EN:        accel_en_reg        <= pwdata[0];
                REG_ENERGY_ACCEL_EN: energy_accel_en_reg <= pwdata[0];
                REG_COLUMNS:         columns_reg         <= pwdata[6:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_DELTA_EN:        prdata = 32'(delta_en_reg);
            REG_ENERGY_DELTA_EN: prdata = 32'(energy_delta_en_reg);
            REG_ACCEL_EN:        prdata = 32'(accel_en_reg);
            REG_ENERGY_ACCEL_EN: prdata = 32'(energy_accel_en_reg);
            REG_COLUMNS:         prdata = 32'(columns_reg);
            default:             prdata = 32'd0;
        endcase
    end

    assign pending  = (FIFO_AW+2)'(fifo_count_reg) + (FIFO_AW+2)'(s1_valid_reg)
                    + (FIFO_AW+2)'(s2_valid_reg) + (FIFO_AW+2)'(s3_valid_reg);
    assign in_stall = pending >= (FIFO_AW+2)'(FIFO_DEPTH);
    assign accept   = in_valid && !in_stall;
    assign in_use   = ({1'b0, column} < columns_reg) && (int'(column) < COLUMNS);

    assign frame_count_used = utterance_start ? 3'd0 : frame_count_reg;
    assign frame_count_next = (frame_end && frame_count_used < FRAME_COUNT_MAX)
                            ? frame_count_used + 3'd1 : frame_count_used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= 3'd0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            lw_valid_reg    <= 1'b0;
            row_valid_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                frame_count_reg <= frame_count_next;
            end
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (wr_en)
            begin
                lw_valid_reg              <= 1'b1;
                row_valid_reg[s2_col_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[s2_col_reg] <= wr_row;
        end
        if (accept && in_use)
        begin
            rd_row_reg <= hist_mem[column];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_ok_reg    <= in_use && row_valid_reg[column];
            s1_value_reg <= feature_value;
            s1_col_reg   <= column;
            s1_fend_reg  <= frame_end;
            s1_use_reg   <= in_use;
            s1_den_reg   <= is_energy ? energy_delta_en_reg : delta_en_reg;
            s1_aen_reg   <= accel_en_reg && (!is_energy || energy_accel_en_reg);
            s1_ge4_reg   <= frame_count_used >= FRAMES_FOR_DELTA;
            s1_ge7_reg   <= frame_count_used >= FRAMES_FOR_ACCEL;
        end
    end

    always_comb
    begin
        s1_mem_row = rd_ok_reg ? rd_row_reg : '0;
        if (s2_valid_reg && s2_use_reg && s2_col_reg == s1_col_reg)
        begin
            s1_base = s2_base_reg;
        end
        else if (lw_valid_reg && lw_col_reg == s1_col_reg)
        begin
            s1_base = lw_row_reg.base;
        end
        else
        begin
            s1_base = s1_mem_row.base;
        end
        if (lw_valid_reg && lw_col_reg == s1_col_reg)
        begin
            s1_delta = lw_row_reg.delta;
        end
        else
        begin
            s1_delta = s1_mem_row.delta;
        end
        s1_sum = widen(s1_base[0]) - (widen(s1_base[3]) <<< 1) - widen(s1_base[2])
               + (widen(s1_value_reg) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        s2_col_reg   <= s1_col_reg;
        s2_fend_reg  <= s1_fend_reg;
        s2_use_reg   <= s1_use_reg;
        s2_den_reg   <= s1_den_reg;
        s2_aen_reg   <= s1_aen_reg;
        s2_ge4_reg   <= s1_ge4_reg;
        s2_ge7_reg   <= s1_ge7_reg;
        s2_sum_reg   <= s1_sum;
        s2_base_reg  <= {s1_base[2:0], s1_value_reg};
        s2_delta_reg <= s1_delta;
    end

    always_comb
    begin
        s2_dh        = (lw_valid_reg && lw_col_reg == s2_col_reg)
                     ? lw_row_reg.delta : s2_delta_reg;
        s2_d         = s2_ge4_reg ? div10_round(s2_sum_reg) : '0;
        wr_row.base  = s2_base_reg;
        wr_row.delta = {s2_dh[2:0], s2_d};
        wr_en        = s2_valid_reg && s2_use_reg;
        s2_partial   = widen(s2_dh[0]) - (widen(s2_dh[3]) <<< 1) - widen(s2_dh[2]);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lw_row_reg <= wr_row;
            lw_col_reg <= s2_col_reg;
        end
        s3_col_reg     <= s2_col_reg;
        s3_fend_reg    <= s2_fend_reg;
        s3_dout_reg    <= s2_use_reg && s2_ge4_reg && s2_den_reg;
        s3_aout_reg    <= s2_use_reg && s2_ge7_reg && s2_aen_reg;
        s3_d_reg       <= s2_d;
        s3_partial_reg <= s2_partial;
    end

    always_comb
    begin
        s3_sum                = s3_partial_reg + (widen(s3_d_reg) <<< 1);
        s3_result.delta_value = s3_dout_reg ? s3_d_reg : '0;
        s3_result.delta_valid = s3_dout_reg;
        s3_result.accel_value = s3_aout_reg ? div10_round(s3_sum) : '0;
        s3_result.accel_valid = s3_aout_reg;
        s3_result.column      = s3_col_reg;
        s3_result.frame_end   = s3_fend_reg;
    end

    assign pop = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            if (s3_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            fifo_count_reg <= fifo_count_reg + (FIFO_AW+1)'(s3_valid_reg)
                            - (FIFO_AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            fifo_mem[wr_ptr_reg] <= s3_result;
        end
    end

    assign head          = fifo_mem[rd_ptr_reg];
    assign out_valid     = fifo_count_reg != '0;
    assign delta_value   = $signed(head.delta_value);
    assign delta_valid   = head.delta_valid;
    assign accel_value   = $signed(head.accel_value);
    assign accel_valid   = head.accel_valid;
    assign column_out    = head.column;
    assign frame_end_out = head.frame_end;

endmodule

// ===== sim/delta_regression_features_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the delta and delta-delta regression feature block.
module delta_regression_features_test;
    import drf_pkg::*;

    localparam int GAP_MAX      = 18;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 12;
    localparam int TOTAL_ITEMS  = 1520;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [COL_W-1:0]        col;
        logic                    energy;
        logic                    fend;
        logic                    ustart;
    } feature_item_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [CFG_AW-1:0]       paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [VAL_W-1:0] feature_value = '0;
    logic [COL_W-1:0]        column = '0;
    logic                    is_energy = 1'b0;
    logic                    frame_end = 1'b0;
    logic                    utterance_start = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [VAL_W-1:0] delta_value;
    logic                    delta_valid;
    logic signed [VAL_W-1:0] accel_value;
    logic                    accel_valid;
    logic [COL_W-1:0]        column_out;
    logic                    frame_end_out;

    logic signed [VAL_W-1:0] base_hist [COLUMNS][HIST];
    logic signed [VAL_W-1:0] delta_hist [COLUMNS][HIST];
    logic [2:0]              frames_done;
    logic                    cfg_delta_en;
    logic                    cfg_energy_delta_en;
    logic                    cfg_accel_en;
    logic                    cfg_energy_accel_en;
    logic [6:0]              cfg_columns;

    result_t                 expected_results [$];
    int                      mismatch_count = 0;
    int                      items_sent = 0;
    int                      idle_cycles = 0;
    int                      tx_gap_max = 0;
    int                      rx_gap_max = 0;
    logic                    hold_request = 1'b0;

    delta_regression_features u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .feature_value   (feature_value),
        .column          (column),
        .is_energy       (is_energy),
        .frame_end       (frame_end),
        .utterance_start (utterance_start),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .delta_value     (delta_value),
        .delta_valid     (delta_valid),
        .accel_value     (accel_value),
        .accel_valid     (accel_valid),
        .column_out      (column_out),
        .frame_end_out   (frame_end_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%s", msg);
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] regression(input longint oldest,
                                                           input longint older,
                                                           input longint newest,
                                                           input longint cur);
        longint s;
        longint q;
        s = -2 * oldest - older + newest + 2 * cur;
        if (s < 0)
        begin
            q = -((-s + 5) / 10);
        end
        else
        begin
            q = (s + 5) / 10;
        end
        return q[VAL_W-1:0];
    endfunction

    function automatic result_t predict_features(input feature_item_t it);
        result_t                 r;
        logic signed [VAL_W-1:0] d;
        logic                    d_en;
        logic                    a_en;
        r = '0;
        d = '0;
        if (it.ustart)
        begin
            frames_done = '0;
        end
        r.column = it.col;
        r.frame_end = it.fend;
        if (it.col < cfg_columns)
        begin
            d_en = it.energy ? cfg_energy_delta_en : cfg_delta_en;
            a_en = cfg_accel_en && (!it.energy || cfg_energy_accel_en);
            if (frames_done >= FRAMES_FOR_DELTA)
            begin
                d = regression(base_hist[it.col][3], base_hist[it.col][2],
                               base_hist[it.col][0], it.value);
                if (d_en)
                begin
                    r.delta_value = d;
                    r.delta_valid = 1'b1;
                end
            end
            if (frames_done >= FRAMES_FOR_ACCEL && a_en)
            begin
                r.accel_value = regression(delta_hist[it.col][3], delta_hist[it.col][2],
                                           delta_hist[it.col][0], d);
                r.accel_valid = 1'b1;
            end
            for (int k = HIST - 1; k > 0; k--)
            begin
                base_hist[it.col][k] = base_hist[it.col][k-1];
                delta_hist[it.col][k] = delta_hist[it.col][k-1];
            end
            base_hist[it.col][0] = it.value;
            delta_hist[it.col][0] = d;
        end
        if (it.fend && frames_done < FRAME_COUNT_MAX)
        begin
            frames_done = frames_done + 3'd1;
        end
        return r;
    endfunction

    task automatic send_item(input feature_item_t it, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        feature_value <= it.value;
        column <= it.col;
        is_energy <= it.energy;
        frame_end <= it.fend;
        utterance_start <= it.ustart;
        do @(posedge clk); while (in_stall);
        expected_results.push_back(predict_features(it));
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
        logic [31:0] mask;
        mask = (idx == REG_COLUMNS) ? 32'h7F : 32'h1;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'({idx, 2'b00});
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== (val & mask))
        begin
            note_mismatch($sformatf("register %s: expected %0h, read %0h",
                                    idx.name(), val & mask, prdata));
        end
        case (idx)
            REG_DELTA_EN:        cfg_delta_en = val[0];
            REG_ENERGY_DELTA_EN: cfg_energy_delta_en = val[0];
            REG_ACCEL_EN:        cfg_accel_en = val[0];
            REG_ENERGY_ACCEL_EN: cfg_energy_accel_en = val[0];
            REG_COLUMNS:         cfg_columns = val[6:0];
            default:             ;
        endcase
    endtask

    task automatic set_config(input logic d_en, input logic ed_en, input logic a_en,
                              input logic ea_en, input logic [6:0] cols);
        wait_idle();
        write_reg(REG_DELTA_EN, {31'd0, d_en});
        write_reg(REG_ENERGY_DELTA_EN, {31'd0, ed_en});
        write_reg(REG_ACCEL_EN, {31'd0, a_en});
        write_reg(REG_ENERGY_ACCEL_EN, {31'd0, ea_en});
        write_reg(REG_COLUMNS, {25'd0, cols});
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return {1'b0, {(VAL_W-1){1'b1}}};
            1:       return {1'b1, {(VAL_W-1){1'b0}}};
            2, 3:    return VAL_W'($urandom);
            default: return VAL_W'($signed($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    function automatic feature_item_t make_item(input logic signed [VAL_W-1:0] value,
                                                input int col, input logic energy,
                                                input logic fend, input logic ustart);
        feature_item_t it;
        it.value = value;
        it.col = COL_W'(col);
        it.energy = energy;
        it.fend = fend;
        it.ustart = ustart;
        return it;
    endfunction

    // Sends whole frames in column order with one energy column; noise_pct of the
    // items are replaced by arbitrary ones and pause_ok allows a full drain mid-run.
    task automatic run_utterance(input int cols, input int frames, input int noise_pct,
                                 input bit pause_ok);
        int            width;
        int            energy_col;
        feature_item_t it;
        width = (cols > COLUMNS) ? COLUMNS : cols;
        energy_col = $urandom_range(0, width - 1);
        for (int f = 0; f < frames; f++)
        begin
            if (pause_ok && f == frames / 2)
            begin
                wait_idle();
            end
            for (int c = 0; c < width; c++)
            begin
                if ($urandom_range(0, 99) < noise_pct)
                begin
                    it = make_item(VAL_W'($urandom), $urandom_range(0, COLUMNS - 1),
                                   1'($urandom), 1'($urandom), $urandom_range(0, 7) == 0);
                end
                else
                begin
                    it = make_item(pick_value(), c, c == energy_col, c == width - 1,
                                   f == 0 && c == 0);
                end
                send_item(it, $urandom_range(0, tx_gap_max));
            end
        end
    endtask

    task automatic test_reset_state();
        send_item(make_item(24'sd1000, 0, 1'b0, 1'b0, 1'b1), 0);
        send_item(make_item(-24'sd1000, 12, 1'b1, 1'b1, 1'b0), 0);
    endtask

    task automatic test_warmup_frames();
        logic signed [VAL_W-1:0] v;
        set_config(1'b1, 1'b1, 1'b1, 1'b1, 7'd2);
        for (int f = 0; f < 8; f++)
        begin
            v = f[0] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
            send_item(make_item(v, 0, 1'b0, 1'b0, f == 0), $urandom_range(0, 2));
            send_item(make_item(VAL_W'(f * 37 - 100), 1, 1'b1, 1'b1, 1'b0), 0);
        end
    endtask

    task automatic test_unused_columns();
        send_item(make_item(24'sd77, 2, 1'b0, 1'b0, 1'b0), 0);
        send_item(make_item(-24'sd1, COLUMNS - 1, 1'b1, 1'b1, 1'b0), 0);
    endtask

    task automatic test_repeated_column();
        send_item(make_item(24'sd500, 0, 1'b0, 1'b0, 1'b0), 0);
        send_item(make_item(-24'sd500, 0, 1'b0, 1'b0, 1'b0), 1);
        send_item(make_item(24'sd3, 1, 1'b1, 1'b1, 1'b0), 0);
    endtask

    task automatic test_config_extremes();
        tx_gap_max = 0;
        rx_gap_max = 0;
        set_config(1'b1, 1'b1, 1'b1, 1'b1, 7'd64);
        run_utterance(64, 8, 0, 1'b0);
        tx_gap_max = GAP_MAX;
        rx_gap_max = GAP_MAX;
        set_config(1'b0, 1'b0, 1'b0, 1'b0, 7'd1);
        run_utterance(1, 10, 5, 1'b0);
        tx_gap_max = 2;
        rx_gap_max = 2;
        set_config(1'b0, 1'b1, 1'b1, 1'b0, 7'd127);
        run_utterance(127, 1, 10, 1'b0);
    endtask

    task automatic test_output_hold();
        tx_gap_max = 0;
        rx_gap_max = 0;
        set_config(1'b1, 1'b0, 1'b1, 1'b1, 7'd4);
        hold_request = 1'b1;
        run_utterance(4, 8, 0, 1'b0);
    endtask

    task automatic test_random_utterances();
        int cols;
        int gap_sel [3] = '{0, 2, GAP_MAX};
        while (items_sent < TOTAL_ITEMS)
        begin
            cols = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            tx_gap_max = gap_sel[$urandom_range(0, 2)];
            rx_gap_max = gap_sel[$urandom_range(0, 2)];
            set_config(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 7'(cols));
            run_utterance(cols, $urandom_range(8, 12), 15, $urandom_range(0, 3) == 0);
        end
    endtask

    // Receiver: a random stall before each item, or the one long hold on request.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                n = $urandom_range(0, rx_gap_max);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                note_mismatch($sformatf("unexpected item for column %0d", column_out));
            end
            else
            begin
                want = expected_results.pop_front();
                if (delta_value !== want.delta_value || delta_valid !== want.delta_valid ||
                    accel_value !== want.accel_value || accel_valid !== want.accel_valid ||
                    column_out !== want.column || frame_end_out !== want.frame_end)
                begin
                    note_mismatch($sformatf(
                        "expected d=%0d/%b a=%0d/%b col=%0d end=%b, got d=%0d/%b a=%0d/%b col=%0d end=%b",
                        $signed(want.delta_value), want.delta_valid,
                        $signed(want.accel_value), want.accel_valid,
                        want.column, want.frame_end,
                        delta_value, delta_valid, accel_value, accel_valid,
                        column_out, frame_end_out));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        for (int c = 0; c < COLUMNS; c++)
        begin
            for (int k = 0; k < HIST; k++)
            begin
                base_hist[c][k] = '0;
                delta_hist[c][k] = '0;
            end
        end
        frames_done = '0;
        cfg_delta_en = 1'b0;
        cfg_energy_delta_en = 1'b0;
        cfg_accel_en = 1'b0;
        cfg_energy_accel_en = 1'b0;
        cfg_columns = COLUMNS_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_warmup_frames();
        test_unused_columns();
        test_repeated_column();
        test_config_extremes();
        test_output_hold();
        test_random_utterances();
        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/drf_pkg.sv
hw/rtl/delta_regression_features.sv
sim/delta_regression_features_test.sv
